// ----- rtl/core/bcdc_pkg.sv -----
package bcdc_pkg;

    // ADC resolution; every code field and product width follows from it
    localparam int ADC_BITS = 12;

    localparam int MV_W      = 16;
    localparam int DRV_W     = 8;
    localparam int CYC_W     = 15;
    localparam int PCT_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 2;

    localparam logic [ADC_BITS-1:0] ADC_FS = '1;

    // code * full-scale product, and the headroom for the rounding divide
    localparam int PROD_W = ADC_BITS + MV_W;
    localparam int SUM_W  = PROD_W + 2;

    // stream packing
    localparam int S_TDATA_W = ((3 * ADC_BITS + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * DRV_W + 2 * MV_W + 1 + CYC_W + 1 + 7) / 8) * 8;

    // single-mode target: (span * percent) / 100 through a reciprocal
    localparam int PCT_PROD_W  = MV_W + PCT_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 18;
    localparam int RECIP_PROD_W = PCT_PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'((1 << RECIP_SHIFT) / 100);
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VMAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VMIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAX        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LEVEL = 3'd6;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CHARGE    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DISCHARGE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CHARGE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] single_mode;
        logic [PCT_W-1:0]  setpoint_percent;
        logic [MV_W-1:0]   vmax_mv;
        logic [MV_W-1:0]   vmin_mv;
        logic [MV_W-1:0]   imax_ma;
        logic [CFG_W-1:0]  cycle_limit;
        logic [DRV_W-1:0]  drive_level;
    } cfg_t;

    typedef struct packed {
        logic                req_type;
        logic [ADC_BITS-1:0] voltage_code;
        logic [ADC_BITS-1:0] charge_current_code;
        logic [ADC_BITS-1:0] discharge_current_code;
        logic                stop_request;
    } in_item_t;

    typedef struct packed {
        logic              req_type;
        logic              stop_request;
        logic [PROD_W-1:0] v_prod;
        logic [PROD_W-1:0] c_prod;
        logic [PROD_W-1:0] d_prod;
    } prod_item_t;

    typedef struct packed {
        logic [DRV_W-1:0] charge_drive;
        logic [DRV_W-1:0] discharge_drive;
        logic [MV_W-1:0]  battery_mv;
        logic [MV_W-1:0]  current_ma;
        logic             charging;
        logic [CYC_W-1:0] cycles_done;
        logic             finished;
        logic             completed;
    } out_item_t;

    // round(prod / FS), half up. FS = 2^ADC_BITS - 1, so the quotient comes
    // from a short geometric series plus one correction step.
    function automatic logic [MV_W-1:0] adc_scale(input logic [PROD_W-1:0] prod);
        logic [SUM_W-1:0] y;
        logic [SUM_W-1:0] t;
        logic [SUM_W-1:0] q0;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] q;
        y  = SUM_W'(prod) + SUM_W'(ADC_FS >> 1);
        t  = y + (y >> ADC_BITS) + (y >> (2 * ADC_BITS));
        q0 = t >> ADC_BITS;
        r  = y + q0 - (q0 << ADC_BITS);
        q  = q0 + ((r >= SUM_W'(ADC_FS)) ? SUM_W'(1) : SUM_W'(0));
        return q[MV_W-1:0];
    endfunction

    // mv * FS, for the exact threshold compare
    function automatic logic [PROD_W-1:0] fs_mul(input logic [MV_W-1:0] mv);
        return (PROD_W'(mv) << ADC_BITS) - PROD_W'(mv);
    endfunction

endpackage

// ----- rtl/core/battery_charge_discharge_cycler.sv -----
// Channel  | Dir | Handshake              | Content
// ---------+-----+------------------------+---------------------------------------------
// s_       | in  | s_tvalid / s_tready    | one request word: start or control tick
// m_       | out | m_tvalid / m_tready    | one status word per request, tlast = run end
// cfg_     | in  | cfg_wr_en (no stall)   | register index + write data, no read-back
//
// Three register stages: input word, ADC products, result word. An accepted word
// passes through the product and result registers before it shows on m_tvalid;
// one word is taken per cycle while s_tready is high. The run state is updated
// as a word moves into the result register. Reset (aresetn, synchronous, low)
// clears state, valids and loads register defaults. After reset or a register
// write, s_tready stays low while the single-mode target settles through its
// three-stage path. Each stage fills whenever it is empty or its successor can
// take its word, so a stalled m_ side only backs up as far as the words in flight.
module battery_charge_discharge_cycler (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [11:0] voltage_code, [23:12] charge_current_code,
    // [35:24] discharge_current_code, [36] stop_request, rest zero
    input  logic [bcdc_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] req_type
    input  logic [0:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] charge_drive, [15:8] discharge_drive, [31:16] battery_mv,
    // [47:32] current_ma, [48] charging, [63:49] cycles_done, [64] completed
    output logic [bcdc_pkg::M_TDATA_W-1:0]      m_tdata,
    // finished
    output logic                                m_tlast,

    input  logic                                cfg_wr_en,
    input  logic [bcdc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bcdc_pkg::CFG_W-1:0]          cfg_wr_data
);
    import bcdc_pkg::*;

    localparam logic [1:0] CFG_SETTLE = 2'd2;

    cfg_t       cfg_reg;
    logic [1:0] settle_reg;

    logic       in_valid_reg;
    in_item_t   in_reg;
    logic       prod_valid_reg;
    prod_item_t prod_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    logic [MV_W-1:0] target_mv;

    logic     en_out;
    logic     en_prod;
    logic     en_in;
    logic     s_accept;
    logic     fire;
    in_item_t in_word;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.single_mode      <= 2'd2;
            cfg_reg.setpoint_percent <= 7'd100;
            cfg_reg.vmax_mv          <= 16'd4200;
            cfg_reg.vmin_mv          <= 16'd3000;
            cfg_reg.imax_ma          <= 16'd1000;
            cfg_reg.cycle_limit      <= '0;
            cfg_reg.drive_level      <= 8'd255;
            settle_reg               <= CFG_SETTLE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SINGLE_MODE: cfg_reg.single_mode      <= cfg_wr_data[MODE_W-1:0];
                CFG_SETPOINT:    cfg_reg.setpoint_percent <= cfg_wr_data[PCT_W-1:0];
                CFG_VMAX:        cfg_reg.vmax_mv          <= cfg_wr_data[MV_W-1:0];
                CFG_VMIN:        cfg_reg.vmin_mv          <= cfg_wr_data[MV_W-1:0];
                CFG_IMAX:        cfg_reg.imax_ma          <= cfg_wr_data[MV_W-1:0];
                CFG_CYCLE_LIMIT: cfg_reg.cycle_limit      <= cfg_wr_data;
                CFG_DRIVE_LEVEL: cfg_reg.drive_level      <= cfg_wr_data[DRV_W-1:0];
                default: ;
            endcase
            settle_reg <= CFG_SETTLE;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor can take its word
    // ------------------------------------------------------------------
    assign en_out   = !out_valid_reg || m_tready;
    assign en_prod  = !prod_valid_reg || en_out;
    assign en_in    = !in_valid_reg || en_prod;
    assign fire     = prod_valid_reg && en_out;
    assign s_tready = en_in && (settle_reg == 2'd0) && !cfg_wr_en;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (en_in) begin
                in_valid_reg <= s_accept;
            end
            if (en_prod) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_comb begin
        in_word.req_type               = s_tuser[0];
        in_word.voltage_code           = s_tdata[ADC_BITS-1:0];
        in_word.charge_current_code    = s_tdata[2*ADC_BITS-1:ADC_BITS];
        in_word.discharge_current_code = s_tdata[3*ADC_BITS-1:2*ADC_BITS];
        in_word.stop_request           = s_tdata[3*ADC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= in_word;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    bcdc_scale u_scale (
        .aclk     (aclk),
        .load     (en_prod && in_valid_reg),
        .item     (in_reg),
        .vmax_mv  (cfg_reg.vmax_mv),
        .imax_ma  (cfg_reg.imax_ma),
        .prod_reg (prod_reg)
    );

    bcdc_target u_target (
        .aclk       (aclk),
        .cfg        (cfg_reg),
        .target_reg (target_mv)
    );

    bcdc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .prod      (prod_reg),
        .cfg       (cfg_reg),
        .target_mv (target_mv),
        .out_reg   (out_reg)
    );

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.finished;
    assign m_tdata  = {
        (M_TDATA_W - (2 * DRV_W + 2 * MV_W + CYC_W + 2))'(0),
        out_reg.completed,
        out_reg.cycles_done,
        out_reg.charging,
        out_reg.current_ma,
        out_reg.battery_mv,
        out_reg.discharge_drive,
        out_reg.charge_drive
    };

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_completed_ends_run: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.completed) |-> m_tlast
    ) else $error("completed status without end of run");

    a_end_drives_off: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (out_reg.charge_drive == '0 && out_reg.discharge_drive == '0)
    ) else $error("converter left driven at end of run");

    a_one_side_driven: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.charge_drive == '0 || out_reg.discharge_drive == '0)
    ) else $error("both converters driven");

    a_cfg_settle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $past(cfg_wr_en) |-> !s_tready
    ) else $error("request taken before register settle");

endmodule

// ----- rtl/core/bcdc_scale.sv -----
module bcdc_scale (
    input  logic                 aclk,
    input  logic                 load,
    input  bcdc_pkg::in_item_t   item,
    input  logic [15:0]          vmax_mv,
    input  logic [15:0]          imax_ma,
    output bcdc_pkg::prod_item_t prod_reg
);
    import bcdc_pkg::*;

    prod_item_t prod_next;

    always_comb begin
        prod_next.req_type     = item.req_type;
        prod_next.stop_request = item.stop_request;
        prod_next.v_prod = PROD_W'(item.voltage_code) * PROD_W'(vmax_mv);
        prod_next.c_prod = PROD_W'(item.charge_current_code) * PROD_W'(imax_ma);
        prod_next.d_prod = PROD_W'(item.discharge_current_code) * PROD_W'(imax_ma);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- rtl/core/bcdc_target.sv -----
module bcdc_target (
    input  logic              aclk,
    input  bcdc_pkg::cfg_t    cfg,
    output logic [15:0]       target_reg
);
    import bcdc_pkg::*;

    // stage A: span * percent
    logic [PCT_PROD_W-1:0]   x_reg;
    logic                    down_a_reg;
    logic [MV_W-1:0]         vmin_a_reg;
    // stage B: times reciprocal of 100
    logic [RECIP_PROD_W-1:0] m_reg;
    logic [PCT_PROD_W-1:0]   x_b_reg;
    logic                    down_b_reg;
    logic [MV_W-1:0]         vmin_b_reg;

    logic [PCT_W-1:0]      p_sat;
    logic                  down;
    logic [MV_W-1:0]       span;
    logic [PCT_PROD_W-1:0] q0;
    logic [PCT_PROD_W-1:0] rem;
    logic [PCT_PROD_W-1:0] quot;
    logic [MV_W-1:0]       target_next;

    always_comb begin
        p_sat = (cfg.setpoint_percent > PCT_FULL) ? PCT_FULL : cfg.setpoint_percent;
        down  = cfg.vmax_mv < cfg.vmin_mv;
        span  = down ? (cfg.vmin_mv - cfg.vmax_mv) : (cfg.vmax_mv - cfg.vmin_mv);
    end

    // quotient estimate is low by at most one
    always_comb begin
        q0   = PCT_PROD_W'(m_reg >> RECIP_SHIFT);
        rem  = x_b_reg - q0 * PCT_PROD_W'(PCT_FULL);
        quot = q0 + ((rem >= PCT_PROD_W'(PCT_FULL)) ? PCT_PROD_W'(1) : PCT_PROD_W'(0));
        target_next = down_b_reg ? (vmin_b_reg - quot[MV_W-1:0])
                                 : (vmin_b_reg + quot[MV_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        x_reg      <= PCT_PROD_W'(span) * PCT_PROD_W'(p_sat);
        down_a_reg <= down;
        vmin_a_reg <= cfg.vmin_mv;
        m_reg      <= RECIP_PROD_W'(x_reg) * RECIP_PROD_W'(PCT_RECIP);
        x_b_reg    <= x_reg;
        down_b_reg <= down_a_reg;
        vmin_b_reg <= vmin_a_reg;
        target_reg <= target_next;
    end

endmodule

// ----- rtl/core/bcdc_ctrl.sv -----
module bcdc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  bcdc_pkg::prod_item_t prod,
    input  bcdc_pkg::cfg_t       cfg,
    input  logic [15:0]          target_mv,
    output bcdc_pkg::out_item_t  out_reg
);
    import bcdc_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CYC_W-1:0]   cycle_index_reg, cycle_index_next;
    logic [MV_W-1:0]    upper_reg, upper_next;
    logic [MV_W-1:0]    lower_reg, lower_next;
    logic               cycling_reg, cycling_next;
    out_item_t          out_next;

    logic [MV_W-1:0]  bmv;
    logic [MV_W-1:0]  cur_c;
    logic [MV_W-1:0]  cur_d;
    logic             reach_up;
    logic             reach_dn;
    logic             reached;
    logic             is_chg;
    logic [CYC_W-1:0] cyc_inc;
    logic             limit_hit;

    always_comb begin
        bmv      = adc_scale(prod.v_prod);
        cur_c    = adc_scale(prod.c_prod);
        cur_d    = adc_scale(prod.d_prod);
        reach_up = prod.v_prod >= fs_mul(upper_reg);
        reach_dn = prod.v_prod <= fs_mul(lower_reg);
        is_chg   = phase_reg == PH_CHARGE;
        reached  = is_chg ? reach_up : reach_dn;
        cyc_inc  = (cycle_index_reg == '1) ? cycle_index_reg
                                           : cycle_index_reg + CYC_W'(1);
        // a negative limit means endless
        limit_hit = !cfg.cycle_limit[CFG_W-1] && (cyc_inc >= cfg.cycle_limit[CYC_W-1:0]);
    end

    always_comb begin
        phase_next       = phase_reg;
        cycle_index_next = cycle_index_reg;
        upper_next       = upper_reg;
        lower_next       = lower_reg;
        cycling_next     = cycling_reg;

        out_next.charge_drive    = '0;
        out_next.discharge_drive = '0;
        out_next.battery_mv      = bmv;
        out_next.current_ma      = '0;
        out_next.charging        = 1'b0;
        out_next.cycles_done     = cycle_index_reg;
        out_next.finished        = 1'b0;
        out_next.completed       = 1'b0;

        if (prod.req_type == REQ_START) begin
            cycle_index_next     = '0;
            out_next.cycles_done = '0;
            if (cfg.cycle_limit != '0) begin
                cycling_next = 1'b1;
                upper_next   = cfg.vmax_mv;
                lower_next   = cfg.vmin_mv;
                phase_next   = PH_CHARGE;
            end else begin
                cycling_next = 1'b0;
                upper_next   = target_mv;
                lower_next   = target_mv;
                case (cfg.single_mode)
                    MODE_CHARGE:    phase_next = PH_CHARGE;
                    MODE_DISCHARGE: phase_next = PH_DISCHARGE;
                    default: begin
                        phase_next        = PH_IDLE;
                        out_next.finished = 1'b1;
                    end
                endcase
            end
            if (phase_next == PH_CHARGE) begin
                out_next.charging   = 1'b1;
                out_next.current_ma = cur_c;
            end else if (phase_next == PH_DISCHARGE) begin
                out_next.current_ma = cur_d;
            end
        end else begin
            case (phase_reg)
                PH_CHARGE, PH_DISCHARGE: begin
                    out_next.charging   = is_chg;
                    out_next.current_ma = is_chg ? cur_c : cur_d;
                    if (prod.stop_request) begin
                        out_next.finished = 1'b1;
                        phase_next        = PH_IDLE;
                    end else begin
                        if (is_chg) begin
                            out_next.charge_drive = cfg.drive_level;
                        end else begin
                            out_next.discharge_drive = cfg.drive_level;
                        end
                        if (reached) begin
                            if (!cycling_reg) begin
                                out_next.finished  = 1'b1;
                                out_next.completed = 1'b1;
                                phase_next         = PH_IDLE;
                            end else if (is_chg) begin
                                phase_next = PH_DISCHARGE;
                            end else begin
                                cycle_index_next = cyc_inc;
                                if (limit_hit) begin
                                    out_next.finished  = 1'b1;
                                    out_next.completed = 1'b1;
                                    phase_next         = PH_IDLE;
                                end else begin
                                    phase_next = PH_CHARGE;
                                end
                            end
                            if (out_next.finished) begin
                                out_next.charge_drive    = '0;
                                out_next.discharge_drive = '0;
                            end
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cycle_index_reg <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
            cycling_reg     <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            cycle_index_reg <= cycle_index_next;
            upper_reg       <= upper_next;
            lower_reg       <= lower_next;
            cycling_reg     <= cycling_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

endmodule
